FILE: hdl/fsfs_pkg.sv
// Shared types and codes for the free segment fit search block.
package fsfs_pkg;

    localparam int SIZE_W  = 16;
    localparam int START_W = 16;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;
    localparam logic [1:0] STRAT_NONE  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } fsfs_state_t;

    // control from the sequencer to the selection unit
    typedef struct packed {
        logic clear;
        logic eval;
    } pick_ctrl_t;

    // outcome of a scan, start already cut to the result width
    typedef struct packed {
        logic               hit;
        logic [START_W-1:0] start;
    } pick_res_t;

endpackage

FILE: hdl/fsfs_mem.sv
// Segment table storage: one write port, one read port with registered data.
module fsfs_mem #(
    parameter int DEPTH  = 64,
    parameter int WORD_W = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/fsfs_pick.sv
// Fit selection unit: folds one table entry per cycle into the running choice.
module fsfs_pick #(
    parameter int ADDR_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fsfs_pkg::pick_ctrl_t            ctrl,
    input  logic [1:0]                      strategy,
    input  logic [fsfs_pkg::SIZE_W-1:0]     req_size,
    input  logic [fsfs_pkg::SIZE_W-1:0]     ent_size,
    input  logic [ADDR_BITS-1:0]            ent_start,
    output fsfs_pkg::pick_res_t             res
);

    import fsfs_pkg::*;

    logic [1:0]          strat_reg;
    logic [SIZE_W-1:0]   req_reg;
    logic                hit_reg;
    logic [SIZE_W-1:0]   best_size_reg;
    logic [ADDR_BITS-1:0] best_start_reg;
    logic                fits;
    logic                take;

    always_comb
    begin
        fits = (ent_size >= req_reg);
        take = fits && (!hit_reg ||
                        (strat_reg == STRAT_BEST  && ent_size < best_size_reg) ||
                        (strat_reg == STRAT_WORST && ent_size > best_size_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.eval && take)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            strat_reg <= strategy;
            req_reg   <= req_size;
        end
        else if (ctrl.eval && take)
        begin
            best_size_reg  <= ent_size;
            best_start_reg <= ent_start;
        end
    end

    assign res.hit   = hit_reg;
    assign res.start = hit_reg ? START_W'(best_start_reg) : '0;

endmodule

FILE: hdl/free_segment_fit_search.sv
// Top level of the free segment fit search block: sequencer, count and result register.
//
// Use: requests arrive on the s_axis channel, results leave on m_axis, one
// result per request. s_tuser carries the mode (0 push, 1 query). A push
// stores a segment at the head of the table, or is refused with
// push_dropped set when the table holds TABLE_DEPTH segments. A query walks
// the table from head to tail and returns found and found_start for first,
// best or worst fit; strategy code 3 or an empty table returns not found.
//
// Timing: one request is in work at a time. A push goes from acceptance
// straight to loading the result. A query reads the memory once per stored
// segment, waits for the registered read data of the last read, then loads
// the result; an empty table or strategy 3 goes straight to the load.
// The scan through the single read port of the segment memory sets the
// query time.
//
// Reset clears the entry count, the sequencer and the result valid flag; the
// memory contents need no clearing since only filled slots are read.
// When the receiver stalls, the result holds in the output register and a
// new request is still taken; its result waits until the register frees.
module free_segment_fit_search #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // seg_start[15:0], seg_size[31:16], req_size[47:32],
                                  // fit_strategy[49:48], zero fill [55:50]
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // found[0], found_start[16:1], push_dropped[17],
                                  // zero fill [23:18]
);

    import fsfs_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = ADDR_BITS + SIZE_W;

    // request fields
    logic [15:0] in_seg_start;
    logic [15:0] in_seg_size;
    logic [15:0] in_req_size;
    logic [1:0]  in_strategy;
    logic        in_accept;

    assign in_seg_start = s_tdata[15:0];
    assign in_seg_size  = s_tdata[31:16];
    assign in_req_size  = s_tdata[47:32];
    assign in_strategy  = s_tdata[49:48];

    fsfs_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic             data_valid_reg;
    logic             is_push_reg, is_push_next;
    logic             dropped_reg, dropped_next;
    logic             out_valid_reg;
    logic [23:0]      out_data_reg;
    logic             out_free;
    logic             table_full;

    // memory and selection hookup
    logic              wr_en;
    logic              rd_en;
    logic [WORD_W-1:0] rd_word;
    pick_ctrl_t        pick_ctrl;
    pick_res_t         pick_res;
    logic              load_out;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_addr_next   = rd_addr_reg;
        is_push_next   = is_push_reg;
        dropped_next   = dropped_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        pick_ctrl.clear = 1'b0;
        pick_ctrl.eval  = data_valid_reg;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pick_ctrl.clear = 1'b1;
                    state_next      = ST_FINISH;
                    if (s_tuser == MODE_PUSH)
                    begin
                        is_push_next = 1'b1;
                        dropped_next = table_full;
                        if (!table_full)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        is_push_next = 1'b0;
                        dropped_next = 1'b0;
                        // walk from the head (newest slot) down to slot zero
                        if (in_strategy != STRAT_NONE && count_reg != '0)
                        begin
                            rd_addr_next = IDX_W'(count_reg - CNT_W'(1));
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
                if (rd_addr_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg - IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // last entry folds into the choice on this edge
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            data_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            data_valid_reg <= rd_en;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        is_push_reg <= is_push_next;
        dropped_reg <= dropped_next;
        if (load_out)
        begin
            // a push reports not found with a zero start
            out_data_reg <= {6'b0, dropped_reg,
                             is_push_reg ? 16'b0 : pick_res.start,
                             !is_push_reg && pick_res.hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    fsfs_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WORD_W (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({ADDR_BITS'(in_seg_start), in_seg_size}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_word)
    );

    fsfs_pick #(
        .ADDR_BITS (ADDR_BITS)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (pick_ctrl),
        .strategy  (in_strategy),
        .req_size  (in_req_size),
        .ent_size  (rd_word[SIZE_W-1:0]),
        .ent_start (rd_word[WORD_W-1:SIZE_W]),
        .res       (pick_res)
    );

endmodule

FILE: hdl/fsfs_checker.sv
// Port-level checks for the free segment fit search block, bound to the top level.
module fsfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    import fsfs_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a refused push never reports a find
    a_drop_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[17] && m_tdata[0]))
        else $error("push_dropped and found both set");

    // not found carries a zero start
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'b0)
        else $error("nonzero start without a find");

    // one request in work at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in work");

    // a query taken while no result is out and answered without a scan never flags a dropped push
    a_query_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == MODE_QUERY && !m_tvalid |=> ##1 !m_tdata[17] || !m_tvalid)
        else $error("query result flagged a dropped push");

endmodule

bind free_segment_fit_search fsfs_checker u_fsfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/free_segment_fit_search_test.sv
// Self-checking testbench for the free segment fit search block.
module free_segment_fit_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fsfs_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_BITS   = 16;

    localparam int PHASE_ITEMS    = 225;
    // Room for a full-table query, which reads every slot, with margin on top.
    localparam int DRAIN_CYCLES   = TABLE_DEPTH + 40;
    localparam int WATCHDOG_LIMIT = 4000;

    // One request as the sender sees it, fields named as on the bus.
    typedef struct packed {
        logic        mode;
        logic [15:0] seg_start;
        logic [15:0] seg_size;
        logic [15:0] req_size;
        logic [1:0]  fit_strategy;
    } seg_request_t;

    // One result, unpacked from m_tdata.
    typedef struct packed {
        logic        found;
        logic [15:0] found_start;
        logic        push_dropped;
    } fit_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // seg_start, seg_size, req_size, fit_strategy, zero fill
    logic        s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // found, found_start, push_dropped, zero fill

    // Requests waiting for the driver, and results owed by the block.
    seg_request_t requests_to_send[$];
    fit_result_t  fit_results_due[$];

    // Predictor state: free segment table in push order, head at the top slot.
    logic [15:0] seg_start_tbl[TABLE_DEPTH];
    logic [15:0] seg_size_tbl[TABLE_DEPTH];
    int          seg_count = 0;

    // Sizes the generator knows to be stored, used to aim queries at real segments.
    logic [15:0] stored_sizes[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  req_taken      = 1'b0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;

    free_segment_fit_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // Apply one request to the predictor: store or refuse a push, or scan the
    // table from head to tail for a query. Strict compares keep the segment
    // nearest the head on a size tie.
    function automatic fit_result_t predict_fit(seg_request_t req);
        fit_result_t res;
        logic [15:0] pick_size;
        res       = '0;
        pick_size = '0;
        if (req.mode == MODE_PUSH)
        begin
            if (seg_count >= TABLE_DEPTH)
            begin
                res.push_dropped = 1'b1;
            end
            else
            begin
                seg_start_tbl[seg_count] = req.seg_start;
                seg_size_tbl[seg_count]  = req.seg_size;
                seg_count++;
            end
        end
        else if (req.fit_strategy != STRAT_NONE)
        begin
            for (int slot = seg_count - 1; slot >= 0; slot--)
            begin
                if (seg_size_tbl[slot] >= req.req_size)
                begin
                    if (!res.found ||
                        (req.fit_strategy == STRAT_BEST && seg_size_tbl[slot] < pick_size) ||
                        (req.fit_strategy == STRAT_WORST && seg_size_tbl[slot] > pick_size))
                    begin
                        res.found       = 1'b1;
                        res.found_start = seg_start_tbl[slot];
                        pick_size       = seg_size_tbl[slot];
                    end
                    // first fit stops at the first adequate segment
                    if (req.fit_strategy == STRAT_FIRST)
                        break;
                end
            end
        end
        return res;
    endfunction

    // Queue a push; the query fields ride along with random content.
    function automatic void queue_push(logic [15:0] start, logic [15:0] size);
        seg_request_t r;
        r.mode         = MODE_PUSH;
        r.seg_start    = start;
        r.seg_size     = size;
        r.req_size     = 16'($urandom);
        r.fit_strategy = 2'($urandom_range(0, 3));
        requests_to_send.push_back(r);
        if (stored_sizes.size() < TABLE_DEPTH)
            stored_sizes.push_back(size);
    endfunction

    // Queue a query; the push fields ride along with random content.
    function automatic void queue_query(logic [15:0] req_size, logic [1:0] strategy);
        seg_request_t r;
        r.mode         = MODE_QUERY;
        r.seg_start    = 16'($urandom);
        r.seg_size     = 16'($urandom);
        r.req_size     = req_size;
        r.fit_strategy = strategy;
        requests_to_send.push_back(r);
    endfunction

    // Hold until every queued request is accepted and every result is back.
    task automatic wait_for_drain();
        while (requests_to_send.size() != 0 || s_tvalid || fit_results_due.size() != 0)
            @(negedge clk);
    endtask

    // Driver: change inputs on the falling edge. Keep a request on the bus
    // until it is taken, then advance to the next one or idle.
    always @(negedge clk)
    begin : driver
        seg_request_t next_req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_tvalid || req_taken)
            begin
                if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = requests_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.mode;
                    s_tdata  <= {6'b0, next_req.fit_strategy, next_req.req_size,
                                 next_req.seg_size, next_req.seg_start};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: sample on the rising edge. Predict on each accepted request,
    // check each accepted result against the oldest prediction, and end the
    // run if no handshake happens for too long.
    always @(posedge clk)
    begin : monitor
        seg_request_t taken;
        fit_result_t  want;
        fit_result_t  got;
        if (rst_n)
        begin
            req_taken = s_tvalid && s_tready;
            if (req_taken)
            begin
                taken.mode         = s_tuser;
                taken.seg_start    = s_tdata[15:0];
                taken.seg_size     = s_tdata[31:16];
                taken.req_size     = s_tdata[47:32];
                taken.fit_strategy = s_tdata[49:48];
                fit_results_due.push_back(predict_fit(taken));
            end

            if (m_tvalid && m_tready)
            begin
                got.found        = m_tdata[0];
                got.found_start  = m_tdata[16:1];
                got.push_dropped = m_tdata[17];
                if (fit_results_due.size() == 0)
                begin
                    $error("result arrived with no request awaiting it");
                    mismatch_count++;
                end
                else
                begin
                    want = fit_results_due.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        mismatch_count++;
                    end
                    if (got.found_start !== want.found_start)
                    begin
                        $error("found_start: expected 0x%04h, got 0x%04h",
                               want.found_start, got.found_start);
                        mismatch_count++;
                    end
                    if (got.push_dropped !== want.push_dropped)
                    begin
                        $error("push_dropped: expected %0d, got %0d",
                               want.push_dropped, got.push_dropped);
                        mismatch_count++;
                    end
                end
            end

            if (req_taken || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** free_segment_fit_search: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          sel;
        int          push_pct;
        int          k;
        logic [15:0] size;
        logic [15:0] req;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;

        // Queries on the empty table: nothing can be found.
        queue_query(16'h0000, STRAT_FIRST);
        queue_query(16'h0000, STRAT_BEST);
        queue_query(16'h0000, STRAT_WORST);
        queue_query(16'h0000, STRAT_NONE);

        // Fill a few slots with extremes and size ties.
        queue_push(16'hFFFF, 16'h0000);
        queue_push(16'h0000, 16'hFFFF);
        queue_push(16'h1234, 16'd100);
        queue_push(16'h5678, 16'd100);
        queue_push(16'hABCD, 16'd50);
        queue_push(16'h0F0F, 16'hFFFF);

        // Zero request: every segment fits, the size-zero one too.
        queue_query(16'h0000, STRAT_FIRST);
        queue_query(16'h0000, STRAT_BEST);
        queue_query(16'h0000, STRAT_WORST);
        queue_query(16'h0000, STRAT_NONE);
        // Largest request: only the two full-size segments fit, head wins.
        queue_query(16'hFFFF, STRAT_FIRST);
        queue_query(16'hFFFF, STRAT_BEST);
        queue_query(16'hFFFF, STRAT_WORST);
        queue_query(16'hFFFF, STRAT_NONE);
        // Exact-size and near-miss requests around the tied pair and the size-50 segment.
        queue_query(16'd100, STRAT_BEST);
        queue_query(16'd101, STRAT_BEST);
        queue_query(16'd51, STRAT_FIRST);
        queue_query(16'd50, STRAT_BEST);
        queue_query(16'd60, STRAT_WORST);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Random phases with different idling. Each starts only once the block
        // has returned everything, so the sender pauses fully between them.
        for (int phase = 1; phase <= 4; phase++)
        begin
            wait_for_drain();
            @(posedge clk);
            case (phase)
                1:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 0;
                end
                3:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            // Fill the table slowly at first, then keep pushing into the full
            // table so refused pushes mix with full-depth scans.
            push_pct = (phase <= 2) ? 15 : 25;

            repeat (PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < push_pct)
                begin
                    if (sel < 40)
                        size = 16'($urandom_range(0, 24));
                    else if (sel < 48)
                        size = sel[0] ? 16'hFFFF : 16'h0000;
                    else
                        size = 16'($urandom);
                    queue_push(16'($urandom), size);
                end
                else
                begin
                    if (sel < 10)
                    begin
                        req = 16'h0000;
                    end
                    else if (sel < 15)
                    begin
                        req = 16'hFFFF;
                    end
                    else if (sel < 65 && stored_sizes.size() != 0)
                    begin
                        // aim at a stored size, or just beside it
                        k   = $urandom_range(0, stored_sizes.size() - 1);
                        req = stored_sizes[k];
                        if (sel >= 45)
                            req = sel[0] ? req + 16'd1 : req - 16'd1;
                    end
                    else
                    begin
                        req = 16'($urandom);
                    end
                    queue_query(req, 2'($urandom_range(0, 3)));
                end
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** free_segment_fit_search: PASSED **");
        else
            $display("** free_segment_fit_search: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
hdl/fsfs_pkg.sv
hdl/fsfs_mem.sv
hdl/fsfs_pick.sv
hdl/free_segment_fit_search.sv
hdl/fsfs_checker.sv
tb/sv/free_segment_fit_search_test.sv
